[rtl/base32_stream_decoder_unit_macros.svh]
// Assertion macros for the base32 stream decoder.
`ifndef BASE32_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE32_STREAM_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define B32SD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b32sd: same-cycle check failed");
`define B32SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b32sd: next-cycle check failed");
`else
`define B32SD_ASSERT_IMP(label, clk, rst, ante, cons)
`define B32SD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/b32sd_pkg.sv]
`default_nettype none

package b32sd_pkg;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_K = 8'h4B;
   localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
   localparam logic [7:0] CHAR_UPPER_N = 8'h4E;
   localparam logic [7:0] CHAR_UPPER_P = 8'h50;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [4:0] SYM_BASE_A     = 5'd0;
   localparam logic [4:0] SYM_BASE_M     = 5'd11;
   localparam logic [4:0] SYM_BASE_P     = 5'd13;
   localparam logic [4:0] SYM_BASE_DIGIT = 5'd24;

   localparam logic [3:0] BYTE_BITS   = 4'd8;
   localparam logic [3:0] SYMBOL_BITS = 4'd5;

   typedef struct packed {
      logic [4:0] value;
      logic       invalid;
   } symbol_type;

   typedef struct packed {
      logic       has_result;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       bad_char;
      logic       end_of_run;
   } result_type;

   typedef struct packed {
      logic [2:0] bit_count;
      logic       error_seen;
   } status_type;

endpackage

`default_nettype wire

[rtl/b32sd_channels.sv]
`default_nettype none

interface b32sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

interface b32sd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       bad_char;
   logic       end_of_run;

   modport source (output valid, output data_byte, output byte_valid, output bad_char,
                   output end_of_run, input ready);
   modport sink (input valid, input data_byte, input byte_valid, input bad_char,
                 input end_of_run, output ready);
endinterface

`default_nettype wire

[rtl/base32_stream_decoder_unit.sv]
// Channel   Direction  Payload
// req_chan  in         char_code[7:0], last
// rsp_chan  out        data_byte[7:0], byte_valid, bad_char, end_of_run
//
// Unless stalled, one request is taken every cycle, then held in the input register.
// The input and result registers hold one entry each; while a result waits on
// rsp_chan.ready one more request is taken, and then req_chan.ready stays low.
// Characters that complete no byte, and those after an invalid one, give no result
// except the last character, which always gives one. Reset is synchronous and
// clears the pending bits, the error flag and both valid flags.
`default_nettype none
`include "base32_stream_decoder_unit_macros.svh"

module base32_stream_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   b32sd_req_if.sink       req_chan,
   b32sd_rsp_if.source     rsp_chan
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_char_ff;
   logic                  s1_last_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   b32sd_pkg::result_type rsp_data_ff;
   logic                  advance;
   logic                  req_take;
   b32sd_pkg::symbol_type symbol;
   b32sd_pkg::result_type result;
   b32sd_pkg::status_type status;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? result.has_result : (rsp_valid_ff && !rsp_chan.ready);

   b32sd_symbol_map u_symbol_map (
      .char_code (s1_char_ff),
      .symbol    (symbol)
   );

   b32sd_packer u_packer (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .symbol (symbol),
      .last   (s1_last_ff),
      .result (result),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         s1_char_ff <= req_chan.char_code;
         s1_last_ff <= req_chan.last;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.data_byte  = rsp_data_ff.data_byte;
   assign rsp_chan.byte_valid = rsp_data_ff.byte_valid;
   assign rsp_chan.bad_char   = rsp_data_ff.bad_char;
   assign rsp_chan.end_of_run = rsp_data_ff.end_of_run;

   // A result that carries no byte is always the closing one.
   `B32SD_ASSERT_IMP(a_empty_is_closing, clock, reset, rsp_valid_ff && !rsp_data_ff.byte_valid, rsp_data_ff.end_of_run)
   // An error result never carries a byte.
   `B32SD_ASSERT_IMP(a_bad_has_no_byte, clock, reset, rsp_valid_ff && rsp_data_ff.bad_char, !rsp_data_ff.byte_valid && rsp_data_ff.end_of_run)
   // After the last character the decoder starts clean.
   `B32SD_ASSERT_NEXT(a_clean_after_last, clock, reset, advance && s1_last_ff, status.bit_count == 3'd0 && !status.error_seen)

endmodule

`default_nettype wire

[rtl/b32sd_symbol_map.sv]
`default_nettype none

module b32sd_symbol_map (
   input  wire logic [7:0]          char_code,
   output b32sd_pkg::symbol_type    symbol
);

   logic [7:0] folded;

   always_comb begin
      if (char_code >= b32sd_pkg::CHAR_LOWER_A && char_code <= b32sd_pkg::CHAR_LOWER_Z) begin
         folded = char_code - b32sd_pkg::CASE_OFFSET;
      end else begin
         folded = char_code;
      end
   end

   always_comb begin
      symbol.invalid = 1'b0;
      symbol.value   = '0;
      if (folded >= b32sd_pkg::CHAR_UPPER_A && folded <= b32sd_pkg::CHAR_UPPER_K) begin
         symbol.value = b32sd_pkg::SYM_BASE_A + 5'(folded - b32sd_pkg::CHAR_UPPER_A);
      end else if (folded >= b32sd_pkg::CHAR_UPPER_M && folded <= b32sd_pkg::CHAR_UPPER_N) begin
         symbol.value = b32sd_pkg::SYM_BASE_M + 5'(folded - b32sd_pkg::CHAR_UPPER_M);
      end else if (folded >= b32sd_pkg::CHAR_UPPER_P && folded <= b32sd_pkg::CHAR_UPPER_Z) begin
         symbol.value = b32sd_pkg::SYM_BASE_P + 5'(folded - b32sd_pkg::CHAR_UPPER_P);
      end else if (folded >= b32sd_pkg::CHAR_DIGIT_2 && folded <= b32sd_pkg::CHAR_DIGIT_9) begin
         symbol.value = b32sd_pkg::SYM_BASE_DIGIT + 5'(folded - b32sd_pkg::CHAR_DIGIT_2);
      end else begin
         symbol.invalid = 1'b1;
      end
   end

endmodule

`default_nettype wire

[rtl/b32sd_packer.sv]
`default_nettype none

module b32sd_packer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire b32sd_pkg::symbol_type symbol,
   input  wire logic                 last,
   output b32sd_pkg::result_type     result,
   output b32sd_pkg::status_type     status
);

   logic [6:0]  bit_store_ff, bit_store_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic        error_seen_ff, error_seen_in;
   logic [11:0] acc;
   logic [3:0]  cnt;
   logic [2:0]  rest;
   logic [11:0] keep_mask;
   logic        have_byte;
   logic [7:0]  byte_out;

   always_comb begin
      acc           = {bit_store_ff, symbol.value};
      cnt           = {1'b0, bit_count_ff} + b32sd_pkg::SYMBOL_BITS;
      rest          = 3'(cnt - b32sd_pkg::BYTE_BITS);
      keep_mask     = (12'd1 << rest) - 12'd1;
      have_byte     = 1'b0;
      byte_out      = '0;
      bit_store_in  = bit_store_ff;
      bit_count_in  = bit_count_ff;
      error_seen_in = error_seen_ff;
      if (!error_seen_ff) begin
         if (symbol.invalid) begin
            error_seen_in = 1'b1;
         end else if (cnt >= b32sd_pkg::BYTE_BITS) begin
            have_byte    = 1'b1;
            byte_out     = 8'(acc >> rest);
            bit_store_in = 7'(acc & keep_mask);
            bit_count_in = rest;
         end else begin
            bit_store_in = acc[6:0];
            bit_count_in = cnt[2:0];
         end
      end

      result.has_result = last || have_byte;
      result.end_of_run = last;
      result.bad_char   = last && error_seen_in;
      result.byte_valid = have_byte && !error_seen_in;
      result.data_byte  = (have_byte && !error_seen_in) ? byte_out : 8'd0;

      status.bit_count  = bit_count_ff;
      status.error_seen = error_seen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_store_ff  <= '0;
         bit_count_ff  <= '0;
         error_seen_ff <= 1'b0;
      end else if (step) begin
         if (last) begin
            bit_store_ff  <= '0;
            bit_count_ff  <= '0;
            error_seen_ff <= 1'b0;
         end else begin
            bit_store_ff  <= bit_store_in;
            bit_count_ff  <= bit_count_in;
            error_seen_ff <= error_seen_in;
         end
      end
   end

endmodule

`default_nettype wire
